FILE: rtl/vcs_pkg.sv
// shared types and constants of the vector cosine similarity unit
package vcs_pkg;

   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int NORM_W     = 42;
   localparam int DOT_W      = NORM_W + 1;
   localparam int ALU_W      = 2 * DOT_W;
   localparam int Q_W        = 16;
   localparam int QUO_W      = 30;
   localparam int MUL_STEPS  = DOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQRT_STEPS = QUO_W / 2;
   localparam int CNT_W      = $clog2(MUL_STEPS);

   localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
   localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {NORM_W{1'b1}}};
   localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {NORM_W{1'b0}}};
   localparam logic [Q_W-1:0]    Q_ONE    = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [Q_W-1:0]    Q_MAX    = {1'b0, {(Q_W-1){1'b1}}};

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_ACC_AA  = 11'b000_0000_0010,
      ST_ACC_BB  = 11'b000_0000_0100,
      ST_ACC_AB  = 11'b000_0000_1000,
      ST_ACC_DOT = 11'b000_0001_0000,
      ST_MUL_NN  = 11'b000_0010_0000,
      ST_MUL_DD  = 11'b000_0100_0000,
      ST_CMP     = 11'b000_1000_0000,
      ST_DIV     = 11'b001_0000_0000,
      ST_SQRT    = 11'b010_0000_0000,
      ST_FIN     = 11'b100_0000_0000
   } state_type;

endpackage

FILE: rtl/vector_cosine_similarity_unit.sv
// Vector cosine similarity unit: one sequencer around a shared wide adder and a 16x16 multiplier
//
// Element pairs enter on the req_ channel, one transaction per pair; req_tlast marks the
// final pair of the two vectors. The unit keeps saturating sums of a*b, a*a and b*b.
// After the last pair one transaction leaves on the rsp_ channel: the similarity in Q1.15
// (truncated toward zero, saturated) and a zero-norm flag in rsp_tuser.
// Each pair is accepted in the idle state and then passes through ACC_AA, ACC_BB, ACC_AB
// and ACC_DOT on the shared multiplier and adder. After the last pair the unit runs
// norm_a*norm_b and dot*dot as 43-step shift-add multiplies, a compare, a 30-step
// restoring divide and a 15-step integer square root, all on the one 86-bit adder,
// and then loads the output register. When dot*dot reaches norm_a*norm_b the divide
// and square root are skipped; a zero norm skips all of it.
// req_tready is high only while the unit waits for a pair.
// The result sits in an output register, so the unit takes further pairs while the
// receiver stalls; a second result waits in the final state until the first is taken.
// Synchronous reset clears the sums, the sequencer and the output valid.
module vector_cosine_similarity_unit
   import vcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // elem_a [15:0], elem_b [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // similarity [15:0]
   output logic        rsp_tuser   // zero_norm [0]
);

   state_type state_ff, state_in;

   logic signed [ELEM_W-1:0] a_ff, a_in, b_ff, b_in;
   logic                     last_ff, last_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [NORM_W-1:0]        na_ff, na_in, nb_ff, nb_in;
   logic [ALU_W-1:0]         rem_ff, rem_in;
   logic [2*NORM_W-1:0]      ab_ff, ab_in;
   logic [DOT_W-1:0]         mcand_ff, mcand_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic                     zn_ff, zn_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                     rsp_zn_ff, rsp_zn_in;

   logic signed [ELEM_W-1:0] mul_x, mul_y;
   logic signed [PROD_W-1:0] mul_p;
   logic [ALU_W-1:0]         alu_x, alu_y, alu_sum;
   logic                     alu_sub, alu_neg;
   logic [ALU_W-1:0]         mul_next;
   logic [DOT_W-1:0]         dmag;
   logic [Q_W-1:0]           sim;

   assign mul_p   = mul_x * mul_y;
   assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + {{(ALU_W-1){1'b0}}, alu_sub};
   assign alu_neg = alu_sum[ALU_W-1];

   // product register of the shift-add multiply: upper half plus addend, lower half shifts out
   assign mul_next = {alu_sum[DOT_W:0], rem_ff[DOT_W-1:1]};

   assign dmag = dot_ff[DOT_W-1] ? (DOT_W'(0) - $unsigned(dot_ff)) : $unsigned(dot_ff);

   always_comb begin
      if (dot_ff[DOT_W-1]) begin
         sim = Q_W'(0) - q_ff;
      end else if (q_ff[Q_W-1]) begin
         sim = Q_MAX;
      end else begin
         sim = q_ff;
      end
   end

   // shared adder operand selection
   always_comb begin
      alu_x   = '0;
      alu_y   = '0;
      alu_sub = 1'b0;
      mul_x   = a_ff;
      mul_y   = a_ff;
      case (state_ff)
         ST_ACC_BB: begin
            alu_x = {{(ALU_W-NORM_W){1'b0}}, na_ff};
            alu_y = {{(ALU_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            mul_x = b_ff;
            mul_y = b_ff;
         end
         ST_ACC_AB: begin
            alu_x = {{(ALU_W-NORM_W){1'b0}}, nb_ff};
            alu_y = {{(ALU_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            mul_x = a_ff;
            mul_y = b_ff;
         end
         ST_ACC_DOT: begin
            alu_x = {{(ALU_W-DOT_W){dot_ff[DOT_W-1]}}, dot_ff};
            alu_y = {{(ALU_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
         ST_MUL_NN, ST_MUL_DD: begin
            alu_x = {{(ALU_W-DOT_W){1'b0}}, rem_ff[ALU_W-1:DOT_W]};
            alu_y = rem_ff[0] ? {{(ALU_W-DOT_W){1'b0}}, mcand_ff} : '0;
         end
         ST_CMP: begin
            alu_x   = rem_ff;
            alu_y   = {{(ALU_W-2*NORM_W){1'b0}}, ab_ff};
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_x   = {rem_ff[ALU_W-2:0], 1'b0};
            alu_y   = {{(ALU_W-2*NORM_W){1'b0}}, ab_ff};
            alu_sub = 1'b1;
         end
         ST_SQRT: begin
            alu_x   = {rem_ff[ALU_W-3:0], quo_ff[QUO_W-1:QUO_W-2]};
            alu_y   = {{(ALU_W-Q_W-2){1'b0}}, q_ff, 2'b01};
            alu_sub = 1'b1;
         end
         default: begin
            alu_x = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      dot_in       = dot_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      rem_in       = rem_ff;
      ab_in        = ab_ff;
      mcand_in     = mcand_ff;
      quo_in       = quo_ff;
      q_in         = q_ff;
      zn_in        = zn_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_zn_in    = rsp_zn_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_in     = req_tdata[ELEM_W-1:0];
               b_in     = req_tdata[2*ELEM_W-1:ELEM_W];
               last_in  = req_tlast;
               state_in = ST_ACC_AA;
            end
         end
         ST_ACC_AA: begin
            prod_in  = mul_p;
            state_in = ST_ACC_BB;
         end
         ST_ACC_BB: begin
            na_in    = (|alu_sum[ALU_W-1:NORM_W]) ? NORM_MAX : alu_sum[NORM_W-1:0];
            prod_in  = mul_p;
            state_in = ST_ACC_AB;
         end
         ST_ACC_AB: begin
            nb_in    = (|alu_sum[ALU_W-1:NORM_W]) ? NORM_MAX : alu_sum[NORM_W-1:0];
            prod_in  = mul_p;
            state_in = ST_ACC_DOT;
         end
         ST_ACC_DOT: begin
            // in range when all bits above the sum width match its sign
            if (&alu_sum[ALU_W-1:DOT_W-1] || ~|alu_sum[ALU_W-1:DOT_W-1]) begin
               dot_in = alu_sum[DOT_W-1:0];
            end else if (alu_neg) begin
               dot_in = DOT_MIN;
            end else begin
               dot_in = DOT_MAX;
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (na_ff == '0 || nb_ff == '0) begin
               q_in     = '0;
               zn_in    = 1'b1;
               state_in = ST_FIN;
            end else begin
               zn_in    = 1'b0;
               rem_in   = {{(ALU_W-NORM_W){1'b0}}, nb_ff};
               mcand_in = {1'b0, na_ff};
               cnt_in   = CNT_W'(MUL_STEPS - 1);
               state_in = ST_MUL_NN;
            end
         end
         ST_MUL_NN: begin
            rem_in = mul_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               ab_in    = mul_next[2*NORM_W-1:0];
               rem_in   = {{(ALU_W-DOT_W){1'b0}}, dmag};
               mcand_in = dmag;
               cnt_in   = CNT_W'(MUL_STEPS - 1);
               state_in = ST_MUL_DD;
            end
         end
         ST_MUL_DD: begin
            rem_in = mul_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // dot^2 >= norm_a*norm_b means the magnitude reaches one
            if (!alu_neg) begin
               q_in     = Q_ONE;
               state_in = ST_FIN;
            end else begin
               quo_in   = '0;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!alu_neg) begin
               rem_in = alu_sum;
            end else begin
               rem_in = alu_x;
            end
            quo_in = {quo_ff[QUO_W-2:0], ~alu_neg};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               rem_in   = '0;
               q_in     = '0;
               cnt_in   = CNT_W'(SQRT_STEPS - 1);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!alu_neg) begin
               rem_in = alu_sum;
            end else begin
               rem_in = alu_x;
            end
            q_in   = {q_ff[Q_W-2:0], ~alu_neg};
            quo_in = {quo_ff[QUO_W-3:0], 2'b00};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sim;
               rsp_zn_in    = zn_ff;
               dot_in       = '0;
               na_in        = '0;
               nb_in        = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dot_ff       <= '0;
         na_ff        <= '0;
         nb_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      ab_ff       <= ab_in;
      mcand_ff    <= mcand_in;
      quo_ff      <= quo_in;
      q_ff        <= q_in;
      zn_ff       <= zn_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zn_ff   <= rsp_zn_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zn_ff;

`ifndef SYNTH
   a_zero_flag_zero_sim: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("zero-norm result with nonzero similarity");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {{(ALU_W-2*NORM_W){1'b0}}, ab_ff}))
      else $error("divide remainder not below divisor");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready))
      |=> (dot_ff == '0 && na_ff == '0 && nb_ff == '0 && rsp_tvalid))
      else $error("sums not cleared after result");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_NN || state_ff == ST_MUL_DD)
      |-> (cnt_ff <= CNT_W'(MUL_STEPS - 1)))
      else $error("multiply step count out of range");
`endif

endmodule

FILE: tb/tb_top.sv
// testbench for vector_cosine_similarity_unit: random and directed element pairs checked against a local model
module tb_top;
   import vcs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      logic                     last;
   } elem_pair_type;

   typedef struct packed {
      logic signed [Q_W-1:0] sim;
      logic                  zero_norm;
   } sim_result_type;

   localparam longint  DOT_HI   = longint'($signed(DOT_MAX));
   localparam longint  DOT_LO   = longint'($signed(DOT_MIN));
   localparam u64_type NORM_TOP = u64_type'(NORM_MAX);
   localparam int      SIM_TOP  = int'($signed(Q_MAX));

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // elem_a [15:0], elem_b [31:16]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // similarity [15:0]
   logic        rsp_tuser;        // zero_norm [0]

   elem_pair_type  pair_q[$];
   sim_result_type sim_expected_q[$];

   // running sums of the model
   longint  dot_acc    = 0;
   u64_type norm_a_acc = 0;
   u64_type norm_b_acc = 0;

   int  errors          = 0;
   int  vectors_queued  = 0;
   int  pairs_sent      = 0;
   int  results_checked = 0;
   int  zero_norm_seen  = 0;
   int  full_scale_seen = 0;
   int  hold_left       = 0;
   int  holds_done      = 0;
   logic calm           = 1'b0;

   vector_cosine_similarity_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // largest q in [0, 32768] with q^2 * na * nb <= dmag^2 * 2^30
   function automatic int cosine_ratio(u64_type dmag, u64_type na, u64_type nb);
      logic [127:0] nn;
      logic [127:0] rhs;
      logic [127:0] lhs;
      int lo;
      int hi;
      int mid;
      nn  = 128'(na) * 128'(nb);
      rhs = (128'(dmag) * 128'(dmag)) << 30;
      lo  = 0;
      hi  = 32768;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         lhs = nn * 128'(u64_type'(mid) * u64_type'(mid));
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                  input logic signed [ELEM_W-1:0] b,
                                  input logic last);
      sim_result_type res;
      u64_type        dmag;
      int             q;
      int             sim;
      dot_acc += longint'(a) * longint'(b);
      if (dot_acc > DOT_HI) dot_acc = DOT_HI;
      if (dot_acc < DOT_LO) dot_acc = DOT_LO;
      norm_a_acc += u64_type'(longint'(a) * longint'(a));
      if (norm_a_acc > NORM_TOP) norm_a_acc = NORM_TOP;
      norm_b_acc += u64_type'(longint'(b) * longint'(b));
      if (norm_b_acc > NORM_TOP) norm_b_acc = NORM_TOP;
      if (!last) return;
      if (norm_a_acc == 0 || norm_b_acc == 0) begin
         res.sim       = '0;
         res.zero_norm = 1'b1;
      end else begin
         dmag = (dot_acc < 0) ? u64_type'(-dot_acc) : u64_type'(dot_acc);
         q    = cosine_ratio(dmag, norm_a_acc, norm_b_acc);
         if (dot_acc < 0) sim = -q;
         else sim = (q > SIM_TOP) ? SIM_TOP : q;
         res.sim       = 16'(sim);
         res.zero_norm = 1'b0;
      end
      sim_expected_q.push_back(res);
      dot_acc    = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
   endtask

   task automatic queue_pair(input int a, input int b, input logic last);
      elem_pair_type p;
      p.a    = 16'(a);
      p.b    = 16'(b);
      p.last = last;
      pair_q.push_back(p);
      if (last) vectors_queued++;
   endtask

   function automatic logic signed [ELEM_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         3:       return 16'($urandom_range(0, 15)) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // one vector with a random length and a random relation between a and b
   task automatic queue_random_vector(inout int items);
      int len;
      int shape;
      int k;
      int pick;
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 128);
      shape = $urandom_range(0, 8);
      k     = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
         a = random_sample();
         case (shape)
            3: b = a;
            4: b = -a;
            5: b = a >>> k;
            6: begin
               if (k[0]) a = '0;
               b = k[0] ? random_sample() : '0;
            end
            7: b = a + $signed(4'($urandom_range(0, 15)));
            default: b = random_sample();
         endcase
         queue_pair(a, b, i == len - 1);
      end
      items += len;
   endtask

   // driver: presents the next pair once the current one is taken
   always @(posedge clock) begin : pair_driver
      elem_pair_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_pair($signed(req_tdata[15:0]), $signed(req_tdata[31:16]), req_tlast);
            pairs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pair_q.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
               nxt = pair_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.b, nxt.a};
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long hold-offs so that results back up into the input side
   always @(posedge clock) begin : hold_counter
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if ((results_checked >= 30 && holds_done == 0) ||
                      (results_checked >= 55 && holds_done == 1)) begin
            hold_left  <= 400;
            holds_done <= holds_done + 1;
         end
      end
   end

   // monitor: checks each result transaction and paces rsp_tready
   always @(posedge clock) begin : result_monitor
      sim_result_type want;
      logic           ready_nxt;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (rsp_tuser) zero_norm_seen++;
            if ($signed(rsp_tdata) == SIM_TOP || $signed(rsp_tdata) == -SIM_TOP - 1)
               full_scale_seen++;
            if (sim_expected_q.size() == 0) begin
               $display("%0t: unexpected result similarity=%0d zero_norm=%0b",
                        $time, $signed(rsp_tdata), rsp_tuser);
               errors++;
            end else begin
               want = sim_expected_q.pop_front();
               if (rsp_tdata !== want.sim) begin
                  $display("%0t: similarity mismatch expected=%0d actual=%0d",
                           $time, want.sim, $signed(rsp_tdata));
                  errors++;
               end
               if (rsp_tuser !== want.zero_norm) begin
                  $display("%0t: zero_norm mismatch expected=%0b actual=%0b",
                           $time, want.zero_norm, rsp_tuser);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            ready_nxt = 1'b0;
         end else begin
            ready_nxt = calm || ($urandom_range(0, 99) >= 32);
         end
         rsp_tready <= ready_nxt;
         calm       <= (results_checked >= 18 && results_checked < 26);
      end
   end

   initial begin
      int items;
      // full-scale and sign extremes, zero norms, single and short vectors
      queue_pair(32767, 32767, 1'b1);
      queue_pair(-32768, -32768, 1'b1);
      queue_pair(-32768, 32767, 1'b1);
      queue_pair(0, 0, 1'b1);
      queue_pair(0, -32768, 1'b1);
      queue_pair(12345, 0, 1'b1);
      queue_pair(1, 1, 1'b1);
      queue_pair(1, -1, 1'b1);
      queue_pair(21845, -21846, 1'b1);
      queue_pair(1, 0, 1'b0);
      queue_pair(0, 1, 1'b1);
      queue_pair(16384, -32768, 1'b0);
      queue_pair(-32768, 16384, 1'b0);
      queue_pair(1, -1, 1'b1);
      queue_pair(0, 0, 1'b0);
      queue_pair(0, 0, 1'b0);
      queue_pair(3, 7, 1'b1);
      queue_pair(-1, -1, 1'b0);
      queue_pair(32767, -32768, 1'b1);
      items = 19;
      while (items < 600) queue_random_vector(items);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pair_q.size() != 0 || req_tvalid || sim_expected_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d pairs in %0d vectors, %0d results checked", pairs_sent,
               vectors_queued, results_checked);
      $display("%0d zero-norm results, %0d full-scale results, %0d long receiver stalls",
               zero_norm_seen, full_scale_seen, holds_done);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
